// ===== src/scp_pkg.sv =====
// ============================================================================
// scp_pkg: shared types and constants for the second chance page replacer
// Holds default sizes, the frame count register layout, the controller
// state encoding and the status group handed from controller to top level.
// ============================================================================
`default_nettype none

package scp_pkg;

    // Default build sizes
    localparam int DEF_MAX_FRAMES = 16;
    localparam int DEF_PAGE_BITS  = 16;

    // Frame count register
    localparam int          CFG_W        = 5;
    localparam logic [4:0]  FRAMES_RESET = 5'd4;

    // Result field widths that do not follow the build sizes
    localparam int FRAME_INDEX_W = 4;
    localparam int TOTAL_W       = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWEEP,
        ST_EVICT,
        ST_DONE
    } scp_state_t;

    typedef struct packed {
        logic                       hit;
        logic                       evicted_valid;
        logic [FRAME_INDEX_W-1:0]   frame_index;
        logic [TOTAL_W-1:0]         hit_total;
        logic [TOTAL_W-1:0]         fault_total;
    } scp_status_t;

endpackage

`default_nettype wire

// ===== src/scp_page_mem.sv =====
// ============================================================================
// scp_page_mem: resident page table
// One write port and one read port; read data is registered, so it shows
// in the cycle after the read address is presented with rd_en high.
// ============================================================================
`default_nettype none

module scp_page_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 16
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/scp_ctrl.sv =====
// ============================================================================
// scp_ctrl: lookup, fill and clock sweep sequencer
// Scans the page memory one frame a cycle for a hit, fills free frames in
// order, and otherwise sweeps the reference bits to pick a victim. Keeps the
// valid and reference bits, fill count, hand and saturating totals.
// ============================================================================
`default_nettype none

module scp_ctrl
    import scp_pkg::*;
#(
    parameter int MAX_FRAMES = DEF_MAX_FRAMES,
    parameter int PAGE_BITS  = DEF_PAGE_BITS,
    parameter int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
    parameter int CNT_W      = $clog2(MAX_FRAMES + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [CNT_W-1:0]     active_count,
    // incoming item
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [PAGE_BITS-1:0] page_number,
    // result toward the output stage
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output scp_status_t               res_status,
    output logic [PAGE_BITS-1:0]      res_evicted_page,
    // page memory
    output logic                      mem_wr_en,
    output logic [IDX_W-1:0]          mem_wr_addr,
    output logic [PAGE_BITS-1:0]      mem_wr_data,
    output logic                      mem_rd_en,
    output logic [IDX_W-1:0]          mem_rd_addr,
    input  wire logic [PAGE_BITS-1:0] mem_rd_data
);

    scp_state_t state_reg, state_next;

    logic [MAX_FRAMES-1:0] valid_reg, valid_next;
    logic [MAX_FRAMES-1:0] ref_reg, ref_next;
    logic [CNT_W-1:0]      fill_reg, fill_next;
    logic [IDX_W-1:0]      hand_reg, hand_next;
    logic [IDX_W-1:0]      sweep_reg, sweep_next;
    logic [TOTAL_W-1:0]    hit_cnt_reg, hit_cnt_next;
    logic [TOTAL_W-1:0]    fault_cnt_reg, fault_cnt_next;
    logic [CNT_W-1:0]      scan_reg, scan_next;
    logic                  rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]      rd_idx_reg, rd_idx_next;

    logic [PAGE_BITS-1:0]  page_reg, page_next;
    logic [IDX_W-1:0]      frame_reg, frame_next;
    logic                  hit_reg, hit_next;
    logic                  ev_valid_reg, ev_valid_next;
    logic [PAGE_BITS-1:0]  ev_page_reg, ev_page_next;

    logic scan_more;
    logic match;
    logic sweep_ref;
    logic fill_free;
    logic res_fire;
    logic [31:0] frame_ext;

    function automatic logic [IDX_W-1:0] wrap_inc(
        input logic [IDX_W-1:0] h,
        input logic [CNT_W-1:0] cnt
    );
        logic [CNT_W-1:0] inc;
        inc = CNT_W'(h) + CNT_W'(1);
        return (inc < cnt) ? inc[IDX_W-1:0] : '0;
    endfunction

    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
        return (v == '1) ? v : v + TOTAL_W'(1);
    endfunction

    assign scan_more = (scan_reg < active_count);
    assign match     = rd_pend_reg && valid_reg[rd_idx_reg] && (mem_rd_data == page_reg);
    assign sweep_ref = ref_reg[sweep_reg];
    assign fill_free = (fill_reg < active_count);
    assign res_fire  = (state_reg == ST_DONE) && res_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    state_next = ST_DONE;
                end
                else if (!scan_more && !rd_pend_reg)
                begin
                    state_next = fill_free ? ST_DONE : ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (!sweep_ref)
                begin
                    state_next = ST_EVICT;
                end
            end
            ST_EVICT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_stall    = 1'b1;
        res_valid   = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = sweep_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_SCAN:
            begin
                mem_rd_en   = !match && scan_more;
                mem_rd_addr = scan_reg[IDX_W-1:0];
            end
            ST_SWEEP:
            begin
                mem_rd_en = !sweep_ref;
            end
            ST_EVICT:
            begin
                mem_rd_en = 1'b0;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign mem_wr_en   = res_fire && !hit_reg;
    assign mem_wr_addr = frame_reg;
    assign mem_wr_data = page_reg;

    // Datapath
    always_comb
    begin
        valid_next     = valid_reg;
        ref_next       = ref_reg;
        fill_next      = fill_reg;
        hand_next      = hand_reg;
        sweep_next     = sweep_reg;
        hit_cnt_next   = hit_cnt_reg;
        fault_cnt_next = fault_cnt_reg;
        scan_next      = scan_reg;
        rd_pend_next   = rd_pend_reg;
        rd_idx_next    = rd_idx_reg;
        page_next      = page_reg;
        frame_next     = frame_reg;
        hit_next       = hit_reg;
        ev_valid_next  = ev_valid_reg;
        ev_page_next   = ev_page_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    page_next    = page_number;
                    scan_next    = '0;
                    rd_pend_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                rd_pend_next = mem_rd_en;
                if (mem_rd_en)
                begin
                    rd_idx_next = scan_reg[IDX_W-1:0];
                    scan_next   = scan_reg + CNT_W'(1);
                end
                if (match)
                begin
                    hit_next      = 1'b1;
                    frame_next    = rd_idx_reg;
                    ev_valid_next = 1'b0;
                    ev_page_next  = '0;
                end
                else if (!scan_more && !rd_pend_reg)
                begin
                    hit_next = 1'b0;
                    if (fill_free)
                    begin
                        frame_next    = fill_reg[IDX_W-1:0];
                        fill_next     = fill_reg + CNT_W'(1);
                        ev_valid_next = 1'b0;
                        ev_page_next  = '0;
                    end
                    else
                    begin
                        // restart the hand if the frame count shrank under it
                        sweep_next = (CNT_W'(hand_reg) < active_count) ? hand_reg : '0;
                    end
                end
            end
            ST_SWEEP:
            begin
                if (sweep_ref)
                begin
                    // second chance: clear and advance
                    ref_next[sweep_reg] = 1'b0;
                    sweep_next          = wrap_inc(sweep_reg, active_count);
                end
                else
                begin
                    frame_next = sweep_reg;
                    hand_next  = wrap_inc(sweep_reg, active_count);
                end
            end
            ST_EVICT:
            begin
                ev_valid_next = valid_reg[frame_reg];
                ev_page_next  = valid_reg[frame_reg] ? mem_rd_data : '0;
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    if (hit_reg)
                    begin
                        ref_next[frame_reg] = 1'b1;
                        hit_cnt_next        = sat_inc(hit_cnt_reg);
                    end
                    else
                    begin
                        valid_next[frame_reg] = 1'b1;
                        ref_next[frame_reg]   = 1'b0;
                        fault_cnt_next        = sat_inc(fault_cnt_reg);
                    end
                end
            end
            default:
            begin
                rd_pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            ref_reg       <= '0;
            fill_reg      <= '0;
            hand_reg      <= '0;
            hit_cnt_reg   <= '0;
            fault_cnt_reg <= '0;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            ref_reg       <= ref_next;
            fill_reg      <= fill_next;
            hand_reg      <= hand_next;
            hit_cnt_reg   <= hit_cnt_next;
            fault_cnt_reg <= fault_cnt_next;
            rd_pend_reg   <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sweep_reg    <= sweep_next;
        scan_reg     <= scan_next;
        rd_idx_reg   <= rd_idx_next;
        page_reg     <= page_next;
        frame_reg    <= frame_next;
        hit_reg      <= hit_next;
        ev_valid_reg <= ev_valid_next;
        ev_page_reg  <= ev_page_next;
    end

    assign frame_ext = 32'(frame_reg);

    always_comb
    begin
        res_status.hit           = hit_reg;
        res_status.evicted_valid = ev_valid_reg;
        res_status.frame_index   = frame_ext[FRAME_INDEX_W-1:0];
        res_status.hit_total     = hit_reg ? sat_inc(hit_cnt_reg) : hit_cnt_reg;
        res_status.fault_total   = hit_reg ? fault_cnt_reg : sat_inc(fault_cnt_reg);
    end

    assign res_evicted_page = ev_page_reg;

endmodule

`default_nettype wire

// ===== src/second_chance_page_replacement.sv =====
// ============================================================================
// second_chance_page_replacement: clock page replacement engine
// Takes one page reference per item and reports hit or fault, the evicted
// page, the frame used and running hit and fault totals.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall, page_number): one page reference per
//   item. Only one item is in work at a time; in_stall is high while busy.
//   Output channel (out_valid / out_stall): one result per item, held in an
//   output register so the next item can start while a result waits.
//   Config channel (cfg_valid / cfg_ready, cfg_data): frame count, always
//   ready; write it only while no item is in work.
// Timing: the page memory is scanned one frame a cycle through its
//   registered read port until a hit or the end of the table. A fault takes
//   the next free frame while one remains; once all frames are full, a
//   reference bit sweep and a victim read follow.
// Reset: clears valid and reference bits, fill count, hand and totals, and
//   sets the frame count to 4. A stalled result holds in the output register
//   and the engine waits with its next result until the register frees up.
`default_nettype none

module second_chance_page_replacement
    import scp_pkg::*;
#(
    parameter int MAX_FRAMES = DEF_MAX_FRAMES,
    parameter int PAGE_BITS  = DEF_PAGE_BITS
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // frame count register
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_W-1:0]         cfg_data,
    // page references
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [PAGE_BITS-1:0]     page_number,
    // results
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic                          hit,
    output logic                          evicted_valid,
    output logic [PAGE_BITS-1:0]          evicted_page,
    output logic [FRAME_INDEX_W-1:0]      frame_index,
    output logic [TOTAL_W-1:0]            hit_total,
    output logic [TOTAL_W-1:0]            fault_total
);

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);

    logic [CFG_W-1:0]     cfg_reg, cfg_next;
    logic [CNT_W-1:0]     active_count;
    logic [31:0]          cfg_ext;

    logic                 res_valid;
    logic                 res_ready;
    scp_status_t          res_status;
    logic [PAGE_BITS-1:0] res_evicted_page;

    logic                 out_valid_reg, out_valid_next;
    scp_status_t          out_status_reg;
    logic [PAGE_BITS-1:0] out_page_reg;

    logic                 mem_wr_en;
    logic [IDX_W-1:0]     mem_wr_addr;
    logic [PAGE_BITS-1:0] mem_wr_data;
    logic                 mem_rd_en;
    logic [IDX_W-1:0]     mem_rd_addr;
    logic [PAGE_BITS-1:0] mem_rd_data;

    assign cfg_ready = 1'b1;
    assign cfg_next  = (cfg_valid && cfg_ready) ? cfg_data : cfg_reg;

    // clamp the frame count to 1..MAX_FRAMES
    assign cfg_ext = 32'(cfg_reg);

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            active_count = CNT_W'(1);
        end
        else if (cfg_ext > 32'(MAX_FRAMES))
        begin
            active_count = CNT_W'(MAX_FRAMES);
        end
        else
        begin
            active_count = CNT_W'(cfg_ext);
        end
    end

    // output register: load when empty or being drained
    assign res_ready      = !out_valid_reg || !out_stall;
    assign out_valid_next = (res_valid && res_ready) ? 1'b1
                          : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= FRAMES_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_status_reg <= res_status;
            out_page_reg   <= res_evicted_page;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = out_status_reg.hit;
    assign evicted_valid = out_status_reg.evicted_valid;
    assign evicted_page  = out_page_reg;
    assign frame_index   = out_status_reg.frame_index;
    assign hit_total     = out_status_reg.hit_total;
    assign fault_total   = out_status_reg.fault_total;

    scp_ctrl #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .active_count     (active_count),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .page_number      (page_number),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .res_status       (res_status),
        .res_evicted_page (res_evicted_page),
        .mem_wr_en        (mem_wr_en),
        .mem_wr_addr      (mem_wr_addr),
        .mem_wr_data      (mem_wr_data),
        .mem_rd_en        (mem_rd_en),
        .mem_rd_addr      (mem_rd_addr),
        .mem_rd_data      (mem_rd_data)
    );

    scp_page_mem #(
        .DEPTH  (MAX_FRAMES),
        .ADDR_W (IDX_W),
        .DATA_W (PAGE_BITS)
    ) u_page_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

`default_nettype wire
